@@ rtl/htfd_pkg.sv @@
// Package for the humidity/temperature frame decoder: codes, constants and CRC step.
`timescale 1ns / 1ps
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Position of the next byte in the six-byte reply
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic QTY_TEMP = 1'b0;
    localparam logic QTY_HUM  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_CRC = 2'd1,
        STAT_BUS = 2'd2
    } status_t;

    // Scale factors in hundredths; the divisor is full scale of the raw word
    localparam int          RAW_FULL     = 65535;
    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [14:0] HUM_SCALE    = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET  = 15'd4500;
    localparam int          PROD_W       = 31;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'd0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// Top level: sensor reply frame decoder with CRC-8 check and fixed-point scaling.
//
//  channel | dir | tdata                  | tuser                          | tlast
//  s_*     | in  | [7:0] data_byte        | [0] bus_fail                   | -
//  m_*     | out | [14:0] reading, [15] 0 | [0] quantity, [2:1] status     | last_of_run
//
// A byte is taken every cycle while the multiply stage can drain; each CRC byte gives one result.
// A bus failure gives two results and holds the input until its second result is loaded.
// Results pass through the multiply stage and the divide-correction output register.
// rst_n clears frame position, CRC and the valid flags asynchronously.
// A stalled m_tready backs up into the multiply stage and then into s_tready.
`timescale 1ns / 1ps
module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] bus_fail
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] reading, [15] zero
    output logic [2:0]  m_tuser,   // [0] quantity, [2:1] status
    output logic        m_tlast
);

    // Frame state
    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;

    // Multiply stage
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_fail_reg, s1_fail_next;
    logic              s1_half_reg, s1_half_next;
    logic              s1_qty_reg, s1_qty_next;
    logic              s1_good_reg, s1_good_next;
    logic [PROD_W-1:0] s1_prod_reg, s1_prod_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        out_qty_reg, out_qty_next;
    logic [14:0] out_reading_reg, out_reading_next;
    status_t     out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    logic        out_load;
    logic        s1_done;
    logic [2:0]  pos_eff;
    logic [15:0] raw;
    logic [14:0] scale;
    logic        crc_byte;
    logic [14:0] div_q0;
    logic [16:0] div_t;
    logic [14:0] div_q;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    // A bus failure entry leaves only after its second result
    assign s1_done  = out_load && (!s1_fail_reg || s1_half_reg);
    assign s_tready = !s1_valid_reg || s1_done;
    assign accept   = s_tvalid && s_tready;

    assign pos_eff  = (pos_reg > POS_H_CRC) ? POS_T_MSB : pos_reg;
    assign crc_byte = (pos_eff == POS_T_CRC) || (pos_eff == POS_H_CRC);
    assign raw      = {high_reg, low_reg};
    assign scale    = (pos_eff == POS_H_CRC) ? HUM_SCALE : TEMP_SCALE;

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        high_next = high_reg;
        low_next  = low_reg;
        if (accept) begin
            if (s_tuser) begin
                pos_next = POS_T_MSB;
                crc_next = CRC_INIT;
            end else begin
                unique case (pos_eff)
                    POS_T_LSB, POS_H_LSB:
                    begin
                        crc_next = crc8_feed(crc_reg, s_tdata);
                        low_next = s_tdata;
                        pos_next = pos_eff + 3'd1;
                    end
                    POS_T_CRC:
                    begin
                        crc_next = CRC_INIT;
                        pos_next = POS_H_MSB;
                    end
                    POS_H_CRC:
                    begin
                        crc_next = CRC_INIT;
                        pos_next = POS_T_MSB;
                    end
                    default:
                    begin
                        // MSB of either word
                        crc_next  = crc8_feed(CRC_INIT, s_tdata);
                        high_next = s_tdata;
                        pos_next  = pos_eff + 3'd1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_fail_next  = s1_fail_reg;
        s1_half_next  = s1_half_reg;
        s1_qty_next   = s1_qty_reg;
        s1_good_next  = s1_good_reg;
        s1_prod_next  = s1_prod_reg;
        if (out_load && s1_fail_reg && !s1_half_reg)
            s1_half_next = 1'b1;
        else if (s1_done) begin
            s1_valid_next = 1'b0;
            s1_half_next  = 1'b0;
        end
        if (accept && (s_tuser || crc_byte)) begin
            s1_valid_next = 1'b1;
            s1_fail_next  = s_tuser;
            s1_half_next  = 1'b0;
            s1_qty_next   = (pos_eff == POS_H_CRC) ? QTY_HUM : QTY_TEMP;
            s1_good_next  = (crc_reg == s_tdata);
            s1_prod_next  = PROD_W'(raw) * PROD_W'(scale);
        end
    end

    // floor(prod / 65535): prod = q0*65535 + (q0 + r0), and q0 + r0 < 2*65535
    assign div_q0 = s1_prod_reg[PROD_W-1:16];
    assign div_t  = 17'(div_q0) + 17'(s1_prod_reg[15:0]);
    assign div_q  = div_q0 + ((div_t >= 17'(RAW_FULL)) ? 15'd1 : 15'd0);

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_qty_next     = out_qty_reg;
        out_reading_next = out_reading_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (out_load) begin
            out_valid_next = 1'b1;
            priority if (s1_fail_reg) begin
                out_qty_next     = s1_half_reg ? QTY_HUM : QTY_TEMP;
                out_reading_next = 15'd0;
                out_status_next  = STAT_BUS;
                out_last_next    = s1_half_reg;
            end else if (!s1_good_reg) begin
                out_qty_next     = s1_qty_reg;
                out_reading_next = 15'd0;
                out_status_next  = STAT_CRC;
                out_last_next    = 1'b1;
            end else begin
                out_qty_next     = s1_qty_reg;
                out_reading_next = (s1_qty_reg == QTY_HUM) ? div_q : div_q - TEMP_OFFSET;
                out_status_next  = STAT_OK;
                out_last_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            high_reg      <= 8'd0;
            low_reg       <= 8'd0;
            s1_valid_reg  <= 1'b0;
            s1_half_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            s1_valid_reg  <= s1_valid_next;
            s1_half_reg   <= s1_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fail_reg     <= s1_fail_next;
        s1_qty_reg      <= s1_qty_next;
        s1_good_reg     <= s1_good_next;
        s1_prod_reg     <= s1_prod_next;
        out_qty_reg     <= out_qty_next;
        out_reading_reg <= out_reading_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reading_reg};
    assign m_tuser  = {out_status_reg, out_qty_reg};
    assign m_tlast  = out_last_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_H_CRC)
        else $error("frame position out of range");

    a_half_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        s1_half_reg |-> (s1_valid_reg && s1_fail_reg))
        else $error("second-half flag without a pending bus failure");

    a_fail_second_is_hum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_fail_reg && !s1_half_reg) |=>
            (s1_valid_reg && s1_fail_reg && s1_half_reg))
        else $error("bus failure entry released before humidity result");

    a_bad_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STAT_OK)) |-> (out_reading_reg == 15'd0))
        else $error("error result carries a nonzero reading");

    a_fail_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |->
            (out_status_reg == STAT_BUS && out_qty_reg == QTY_TEMP))
        else $error("non-final result that is not the bus failure temperature");

endmodule

@@ bench/humidity_temp_frame_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the sensor frame decoder: CRC-checked frames, bus failures and scaled readings.
module humidity_temp_frame_decoder_core_tb;
    import htfd_pkg::*;

    localparam int     IDLE_LIMIT   = 1000;
    localparam int     DRAIN_CYCLES = 10;
    localparam int     NO_FAIL      = -1;
    localparam longint TEMP_SPAN    = 17500;
    localparam longint TEMP_BASE    = 4500;
    localparam longint HUM_SPAN     = 10000;

    typedef struct {
        logic        qty;
        logic [14:0] reading;
        status_t     status;
        logic        last;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] bus_fail
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [14:0] reading, [15] zero
    logic [2:0]  m_tuser;   // [0] quantity, [2:1] status
    logic        m_tlast;

    reading_t    expected_readings[$];
    logic [2:0]  frame_pos;
    logic [7:0]  word_crc;
    logic [7:0]  word_msb;
    logic [7:0]  word_lsb;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    bit          no_idle = 1'b0;

    always #2 clk = ~clk;

    humidity_temp_frame_decoder_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [7:0] word_check(input logic [15:0] raw);
        return crc8_step(crc8_step(CRC_INIT, raw[15:8]), raw[7:0]);
    endfunction

    // Exact rational scaling, floored toward minus infinity
    function automatic logic [14:0] scale_reading(input logic qty, input logic [15:0] raw);
        longint num;
        longint val;
        if (qty == QTY_TEMP)
            num = TEMP_SPAN * longint'(raw) - TEMP_BASE * RAW_FULL;
        else
            num = HUM_SPAN * longint'(raw);
        val = (num >= 0) ? num / RAW_FULL : -((-num + RAW_FULL - 1) / RAW_FULL);
        if (qty == QTY_HUM && val > HUM_SPAN)
            val = HUM_SPAN;
        if (qty == QTY_HUM && val < 0)
            val = 0;
        return val[14:0];
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fail);
        reading_t r;
        if (fail)
        begin
            r.qty = QTY_TEMP;
            r.reading = '0;
            r.status = STAT_BUS;
            r.last = 1'b0;
            expected_readings.push_back(r);
            r.qty = QTY_HUM;
            r.last = 1'b1;
            expected_readings.push_back(r);
            frame_pos = POS_T_MSB;
            word_crc = CRC_INIT;
            return;
        end
        case (frame_pos)
            POS_T_MSB, POS_H_MSB:
            begin
                word_crc = crc8_step(CRC_INIT, b);
                word_msb = b;
                frame_pos = frame_pos + 3'd1;
            end
            POS_T_LSB, POS_H_LSB:
            begin
                word_crc = crc8_step(word_crc, b);
                word_lsb = b;
                frame_pos = frame_pos + 3'd1;
            end
            POS_T_CRC, POS_H_CRC:
            begin
                r.qty = (frame_pos == POS_H_CRC) ? QTY_HUM : QTY_TEMP;
                r.last = 1'b1;
                if (word_crc == b)
                begin
                    r.status = STAT_OK;
                    r.reading = scale_reading(r.qty, {word_msb, word_lsb});
                end
                else
                begin
                    r.status = STAT_CRC;
                    r.reading = '0;
                end
                expected_readings.push_back(r);
                word_crc = CRC_INIT;
                frame_pos = (frame_pos == POS_H_CRC) ? POS_T_MSB : POS_H_MSB;
            end
            default:
                frame_pos = POS_T_MSB;
        endcase
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
    endtask

    // Called at a rising edge; returns at the edge where the request is taken
    task automatic send_byte(input logic [7:0] b, input logic fail);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fail;
        // Hold the request until the core takes it
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        predict_byte(b, fail);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic t_bad, input logic h_bad, input int fail_at);
        logic [7:0] frame [6];
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_check(t_raw);
        h_crc = word_check(h_raw);
        if (t_bad)
            t_crc = t_crc ^ (8'h01 << $urandom_range(0, 7));
        if (h_bad)
            h_crc = h_crc ^ (8'h01 << $urandom_range(0, 7));
        frame = '{t_raw[15:8], t_raw[7:0], t_crc, h_raw[15:8], h_raw[7:0], h_crc};
        for (int i = 0; i < 6; i++)
        begin
            if (i == fail_at)
            begin
                send_byte(8'($urandom), 1'b1);
                return;
            end
            send_byte(frame[i], 1'b0);
        end
    endtask

    task automatic test_extreme_words();
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, NO_FAIL);
    endtask

    // A bad CRC on one word must not disturb the other
    task automatic test_crc_mismatch();
        send_frame(16'h0001, 16'h0000, 1'b1, 1'b0, NO_FAIL);
        send_frame(16'hFFFF, 16'h8000, 1'b0, 1'b1, NO_FAIL);
    endtask

    task automatic test_bus_fail();
        send_frame(16'h1234, 16'h5678, 1'b0, 1'b0, 0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 5);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (10) send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, NO_FAIL);
        no_idle = 1'b0;
    endtask

    task automatic test_random_frames(input int count);
        int goal;
        int kind;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
        begin
            // Realign after noise with a bus failure
            if (frame_pos != POS_T_MSB)
                send_byte(8'($urandom), 1'b1);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 6) == 0,
                           $urandom_range(0, 6) == 0, NO_FAIL);
            else if (kind == 7)
                send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, $urandom_range(0, 5));
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin : result_drain
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid) @(negedge clk);
            @(posedge clk);
        end
    end

    // Outputs settle by the falling edge; a request seen here is taken at the next rise
    always @(negedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected result", m_tdata, 16'd0);
            else
            begin
                want = expected_readings.pop_front();
                if (m_tuser[0] !== want.qty)
                    report_mismatch("quantity", 16'(m_tuser[0]), 16'(want.qty));
                if (m_tuser[2:1] !== want.status)
                    report_mismatch("status", 16'(m_tuser[2:1]), 16'(want.status));
                if (m_tdata !== {1'b0, want.reading})
                    report_mismatch("reading", m_tdata, {1'b0, want.reading});
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", 16'(m_tlast), 16'(want.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        frame_pos = POS_T_MSB;
        word_crc = CRC_INIT;
        word_msb = '0;
        word_lsb = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_words();
        test_crc_mismatch();
        test_bus_fail();
        test_back_to_back();
        test_random_frames(370);
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ humidity_temp_frame_decoder_core.f @@
rtl/htfd_pkg.sv
rtl/humidity_temp_frame_decoder_core.sv
bench/humidity_temp_frame_decoder_core_tb.sv
